/* sv/ddc_pkg.sv */
`default_nettype none
package ddc_pkg;

    // Store geometry and transfer limits.
    localparam int MEM_BYTES       = 1024;
    localparam int BLOCK_BYTES     = 128;
    localparam int TX_BUFFER_BYTES = 32;
    localparam int STORE_DEPTH     = 2 * MEM_BYTES;
    localparam int ST_AW           = $clog2(STORE_DEPTH);
    localparam int TX_MAX          = (BLOCK_BYTES < TX_BUFFER_BYTES) ?
                                     BLOCK_BYTES : TX_BUFFER_BYTES;
    localparam int LEN_W           = $clog2(TX_MAX + 1);

    // Allowed values of the one-byte bus writes.
    localparam logic [7:0] OFFSET_LOW  = 8'h00;
    localparam logic [7:0] OFFSET_HIGH = 8'h80;
    localparam logic [7:0] SEGMENT_MAX = 8'h7F;

    // Opcodes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ADDR = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_VAL  = 3'd3;
    localparam logic [2:0] ST_BEYOND   = 3'd4;

    // Address decode targets.
    localparam logic [1:0] TGT_PRIMARY   = 2'd0;
    localparam logic [1:0] TGT_SECONDARY = 2'd1;
    localparam logic [1:0] TGT_SEGMENT   = 2'd2;
    localparam logic [1:0] TGT_NONE      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_PRIMARY_ADDR   = 3'd0;
    localparam logic [2:0] REG_SECONDARY_ADDR = 3'd1;
    localparam logic [2:0] REG_SEGMENT_ADDR   = 3'd2;
    localparam logic [2:0] REG_PRIMARY_USED   = 3'd3;
    localparam logic [2:0] REG_SECONDARY_USED = 3'd4;

    typedef struct packed {
        logic [6:0] primary_address;
        logic [6:0] secondary_address;
        logic [6:0] segment_address;
        logic [9:0] primary_used;
        logic [9:0] secondary_used;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [ST_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic [ST_AW-1:0] raddr;
    } t_store_req;

endpackage
`default_nettype wire

/* sv/ddc_regs.sv */
`default_nettype none
module ddc_regs
    import ddc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite & pready;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.primary_address   <= 7'd80;
            r_cfg.secondary_address <= 7'd81;
            r_cfg.segment_address   <= 7'd48;
            r_cfg.primary_used      <= 10'd0;
            r_cfg.secondary_used    <= 10'd0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_PRIMARY_ADDR:   r_cfg.primary_address   <= pwdata[6:0];
                REG_SECONDARY_ADDR: r_cfg.secondary_address <= pwdata[6:0];
                REG_SEGMENT_ADDR:   r_cfg.segment_address   <= pwdata[6:0];
                REG_PRIMARY_USED:   r_cfg.primary_used      <= pwdata[9:0];
                REG_SECONDARY_USED: r_cfg.secondary_used    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_PRIMARY_ADDR:   prdata = {25'd0, r_cfg.primary_address};
            REG_SECONDARY_ADDR: prdata = {25'd0, r_cfg.secondary_address};
            REG_SEGMENT_ADDR:   prdata = {25'd0, r_cfg.segment_address};
            REG_PRIMARY_USED:   prdata = {22'd0, r_cfg.primary_used};
            REG_SECONDARY_USED: prdata = {22'd0, r_cfg.secondary_used};
            default:            prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/ddc_store.sv */
`default_nettype none
module ddc_store
    import ddc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_store_req i_req,
    output logic      [7:0] o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* sv/ddc_ctrl.sv */
`default_nettype none
module ddc_ctrl
    import ddc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic [6:0] i_dev_address,
    input  wire logic [5:0] i_write_count,
    input  wire logic [7:0] i_write_byte,
    input  wire logic       i_bank,
    input  wire logic [9:0] i_load_index,
    output t_store_req      o_store_req,
    input  wire logic [7:0] i_rd_data,
    output logic            o_strobe,
    output logic      [2:0] o_status,
    output logic            o_data_valid,
    output logic      [7:0] o_data_byte,
    output logic            o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_pri_off, n_pri_off;
    logic [7:0]       r_sec_off, n_sec_off;
    logic [6:0]       r_segment, n_segment;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_tgt_sec, n_tgt_sec;
    logic [ST_AW-1:0] r_raddr;

    // Accepted word.
    logic [1:0] r_opcode;
    logic [6:0] r_dev;
    logic [5:0] r_count;
    logic [7:0] r_wbyte;
    logic       r_bank;
    logic [9:0] r_idx;

    // Result register.
    logic       r_strobe, n_strobe;
    logic [2:0] r_status, n_status;
    logic       r_dvalid, n_dvalid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;

    logic [1:0]       target;
    logic [14:0]      pos;
    logic [15:0]      used_eff;
    logic [15:0]      remain;
    logic [LEN_W-1:0] len;
    logic [31:0]      base_full;
    logic [31:0]      load_full;
    logic             accept;
    t_store_req       req;

    assign accept = i_start & (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Primary wins over secondary, secondary over segment.
    always_comb begin
        if (r_dev == i_cfg.primary_address) begin
            target = TGT_PRIMARY;
        end else if (r_dev == i_cfg.secondary_address) begin
            target = TGT_SECONDARY;
        end else if (r_dev == i_cfg.segment_address) begin
            target = TGT_SEGMENT;
        end else begin
            target = TGT_NONE;
        end
    end

    always_comb begin
        pos      = {r_segment, (target == TGT_SECONDARY) ? r_sec_off : r_pri_off};
        used_eff = {6'd0, (target == TGT_SECONDARY) ? i_cfg.secondary_used
                                                    : i_cfg.primary_used};
        if (used_eff > 16'(MEM_BYTES)) begin
            used_eff = 16'(MEM_BYTES);
        end
        remain = used_eff - {1'b0, pos};
        if (remain > 16'(TX_MAX)) begin
            len = LEN_W'(TX_MAX);
        end else begin
            len = remain[LEN_W-1:0];
        end
        base_full = ((target == TGT_SECONDARY) ? 32'(MEM_BYTES) : 32'd0) + {17'd0, pos};
        load_full = (r_bank ? 32'(MEM_BYTES) : 32'd0) + {22'd0, r_idx};
    end

    always_comb begin
        n_state   = r_state;
        n_pri_off = r_pri_off;
        n_sec_off = r_sec_off;
        n_segment = r_segment;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_tgt_sec = r_tgt_sec;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_dvalid  = 1'b0;
        n_byte    = 8'd0;
        n_last    = 1'b1;
        req.we    = 1'b0;
        req.waddr = load_full[ST_AW-1:0];
        req.wdata = r_wbyte;
        req.raddr = r_raddr + 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept && i_opcode != OP_NONE) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                unique case (r_opcode)
                    OP_WRITE: begin
                        if (target == TGT_NONE) begin
                            n_status = ST_BAD_ADDR;
                        end else if (r_count != 6'd1) begin
                            n_status = ST_BAD_LEN;
                        end else if (target == TGT_SEGMENT) begin
                            if (r_wbyte > SEGMENT_MAX) begin
                                n_status = ST_BAD_VAL;
                            end else begin
                                n_segment = r_wbyte[6:0];
                            end
                        end else if (r_wbyte != OFFSET_LOW && r_wbyte != OFFSET_HIGH) begin
                            n_status = ST_BAD_VAL;
                        end else if (target == TGT_PRIMARY) begin
                            n_pri_off = r_wbyte;
                        end else begin
                            n_sec_off = r_wbyte;
                        end
                    end
                    OP_READ: begin
                        if (target == TGT_SEGMENT || target == TGT_NONE) begin
                            n_status = ST_BAD_ADDR;
                        end else if ({1'b0, pos} > used_eff) begin
                            n_status = ST_BEYOND;
                        end else if (len == '0) begin
                            n_segment = 7'd0;
                        end else begin
                            // First byte is fetched now; S_STREAM registers it.
                            n_strobe  = 1'b0;
                            n_state   = S_STREAM;
                            n_len     = len;
                            n_cnt     = '0;
                            n_tgt_sec = (target == TGT_SECONDARY);
                            req.raddr = base_full[ST_AW-1:0];
                        end
                    end
                    OP_LOAD: begin
                        if ({22'd0, r_idx} >= 32'(MEM_BYTES)) begin
                            n_status = ST_BAD_ADDR;
                        end else begin
                            req.we = 1'b1;
                        end
                    end
                    default: begin
                        n_strobe = 1'b0;
                    end
                endcase
            end
            S_STREAM: begin
                n_strobe = 1'b1;
                n_dvalid = 1'b1;
                n_byte   = i_rd_data;
                n_cnt    = r_cnt + 1'b1;
                n_last   = (n_cnt == r_len);
                if (n_last) begin
                    n_state   = S_IDLE;
                    n_segment = 7'd0;
                    if (r_tgt_sec) begin
                        n_sec_off = r_sec_off + {{(8 - LEN_W){1'b0}}, r_len};
                    end else begin
                        n_pri_off = r_pri_off + {{(8 - LEN_W){1'b0}}, r_len};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pri_off <= 8'd0;
            r_sec_off <= 8'd0;
            r_segment <= 7'd0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pri_off <= n_pri_off;
            r_sec_off <= n_sec_off;
            r_segment <= n_segment;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_cnt     <= n_cnt;
        r_tgt_sec <= n_tgt_sec;
        r_raddr   <= req.raddr;
        r_status  <= n_status;
        r_dvalid  <= n_dvalid;
        r_byte    <= n_byte;
        r_last    <= n_last;
        if (accept) begin
            r_opcode <= i_opcode;
            r_dev    <= i_dev_address;
            r_count  <= i_write_count;
            r_wbyte  <= i_write_byte;
            r_bank   <= i_bank;
            r_idx    <= i_load_index;
        end
    end

    assign o_store_req  = req;
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_data_valid = r_dvalid;
    assign o_data_byte  = r_byte;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_last |-> r_state == S_IDLE)
        else $error("final result seen while sequencer still active");

    a_plain_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_dvalid |-> r_last)
        else $error("result without data not marked last");

    a_stream_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STREAM |-> r_cnt < r_len)
        else $error("stream count ran past transfer length");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_opcode != OP_NONE |=> r_state == S_DECODE)
        else $error("accepted word not decoded");
`endif

endmodule
`default_nettype wire

/* sv/ddc_edid_target.sv */
`default_nettype none
// Channel    Direction  Handshake                        Payload
// command    in         start, busy                      i_opcode .. i_load_index
// result     out        o_strobe (one cycle, no stall)   o_status .. o_last
// config     in/out     psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A write, a load or a read without data goes through the decode state and
// the result register to its result. A read with data sends one byte per
// cycle, len bytes (len at most 32): the first goes through the decode state,
// the registered single read port of the store and the result register. busy
// is high while the sequencer works; the result after it drops may overlap
// the next accept. Reset is synchronous; the byte store holds no reset value.
module ddc_edid_target
    import ddc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [6:0]  i_dev_address,
    input  wire logic [5:0]  i_write_count,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic        i_bank,
    input  wire logic [9:0]  i_load_index,
    output logic             o_strobe,
    output logic      [2:0]  o_status,
    output logic             o_data_valid,
    output logic      [7:0]  o_data_byte,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg       cfg;
    t_store_req store_req;
    logic [7:0] rd_data;

    ddc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ddc_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    ddc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_start       (start),
        .o_busy        (busy),
        .i_opcode      (i_opcode),
        .i_dev_address (i_dev_address),
        .i_write_count (i_write_count),
        .i_write_byte  (i_write_byte),
        .i_bank        (i_bank),
        .i_load_index  (i_load_index),
        .o_store_req   (store_req),
        .i_rd_data     (rd_data),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_data_valid  (o_data_valid),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

/* sim/tb_ddc_edid_target.sv */
`timescale 1ns / 1ps
module tb_ddc_edid_target;
    import ddc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 56;
    localparam int REPORT_CAP = 20;
    localparam logic [6:0] RESET_PRIMARY_ADDR = 7'd80;
    localparam logic [6:0] RESET_SECONDARY_ADDR = 7'd81;
    localparam logic [6:0] RESET_SEGMENT_ADDR = 7'd48;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] dev_address;
        logic [5:0] write_count;
        logic [7:0] write_byte;
        logic       bank;
        logic [9:0] load_index;
    } t_command;

    typedef struct packed {
        logic [2:0] status;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       final_flag;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = OP_NONE;
    logic [6:0]  i_dev_address = '0;
    logic [5:0]  i_write_count = '0;
    logic [7:0]  i_write_byte = '0;
    logic        i_bank = 1'b0;
    logic [9:0]  i_load_index = '0;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's registers, pointers and byte store.
    t_cfg        cfg_shadow;
    logic [7:0]  word_offset [2];
    logic [6:0]  segment_ptr;
    logic [7:0]  store_shadow [STORE_DEPTH];
    bit          store_written [STORE_DEPTH];

    t_reply      replies_due [$];
    t_reply      reply_head;
    bit          idle_gaps_on = 1'b1;
    int          bad_replies = 0;
    int          replies_checked = 0;
    int          words_sent = 0;
    int          data_reads = 0;
    int          settings_applied = 0;
    int          cycle_count = 0;

    ddc_edid_target u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_dev_address (i_dev_address),
        .i_write_count (i_write_count),
        .i_write_byte  (i_write_byte),
        .i_bank        (i_bank),
        .i_load_index  (i_load_index),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_data_valid  (o_data_valid),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_cfg make_config(input logic [6:0] prim, input logic [6:0] sec,
                                         input logic [6:0] seg, input logic [9:0] prim_used,
                                         input logic [9:0] sec_used);
        t_cfg c;
        c.primary_address = prim;
        c.secondary_address = sec;
        c.segment_address = seg;
        c.primary_used = prim_used;
        c.secondary_used = sec_used;
        return c;
    endfunction

    function automatic t_cfg random_config();
        return make_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                           7'($urandom_range(0, 127)), 10'($urandom_range(0, 1023)),
                           10'($urandom_range(0, 1023)));
    endfunction

    function automatic t_command make_cmd(input logic [1:0] op, input logic [6:0] addr,
                                          input logic [5:0] count, input logic [7:0] value,
                                          input logic bank, input logic [9:0] index);
        t_command c;
        c.opcode = op;
        c.dev_address = addr;
        c.write_count = count;
        c.write_byte = value;
        c.bank = bank;
        c.load_index = index;
        return c;
    endfunction

    // Primary wins over secondary, secondary over the segment pointer.
    function automatic logic [1:0] decode_target(input logic [6:0] addr);
        if (addr == cfg_shadow.primary_address) return TGT_PRIMARY;
        if (addr == cfg_shadow.secondary_address) return TGT_SECONDARY;
        if (addr == cfg_shadow.segment_address) return TGT_SEGMENT;
        return TGT_NONE;
    endfunction

    function automatic void read_window(input logic [1:0] tgt, output int pos,
                                        output int len, output bit beyond);
        int used;
        used = (tgt == TGT_PRIMARY) ? int'(cfg_shadow.primary_used)
                                    : int'(cfg_shadow.secondary_used);
        if (used > MEM_BYTES) used = MEM_BYTES;
        pos = int'(word_offset[tgt[0]]) + 256 * int'(segment_ptr);
        beyond = (pos > used);
        len = beyond ? 0 : used - pos;
        if (len > BLOCK_BYTES) len = BLOCK_BYTES;
        if (len > TX_BUFFER_BYTES) len = TX_BUFFER_BYTES;
    endfunction

    function automatic void push_reply(input logic [2:0] status, input logic valid,
                                       input logic [7:0] value, input logic final_flag);
        t_reply r;
        r.status = status;
        r.data_valid = valid;
        r.data_byte = value;
        r.final_flag = final_flag;
        replies_due.push_back(r);
    endfunction

    // Works out the replies to one accepted command and updates the shadow state.
    function automatic void predict_edid_reply(input t_command c);
        logic [1:0] tgt;
        logic [2:0] status;
        int pos;
        int len;
        int base;
        bit beyond;
        tgt = decode_target(c.dev_address);
        case (c.opcode)
            OP_WRITE: begin
                status = ST_OK;
                if (tgt == TGT_NONE) begin
                    status = ST_BAD_ADDR;
                end else if (c.write_count != 6'd1) begin
                    status = ST_BAD_LEN;
                end else if (tgt == TGT_SEGMENT) begin
                    if (c.write_byte > SEGMENT_MAX) status = ST_BAD_VAL;
                    else segment_ptr = c.write_byte[6:0];
                end else if (c.write_byte != OFFSET_LOW && c.write_byte != OFFSET_HIGH) begin
                    status = ST_BAD_VAL;
                end else begin
                    word_offset[tgt[0]] = c.write_byte;
                end
                push_reply(status, 1'b0, 8'h00, 1'b1);
            end
            OP_READ: begin
                if (tgt != TGT_PRIMARY && tgt != TGT_SECONDARY) begin
                    push_reply(ST_BAD_ADDR, 1'b0, 8'h00, 1'b1);
                end else begin
                    read_window(tgt, pos, len, beyond);
                    if (beyond) begin
                        push_reply(ST_BEYOND, 1'b0, 8'h00, 1'b1);
                    end else begin
                        base = int'(tgt[0]) * MEM_BYTES + pos;
                        for (int i = 0; i < len; i++)
                            push_reply(ST_OK, 1'b1, store_shadow[(base + i) % STORE_DEPTH],
                                       i == len - 1);
                        segment_ptr = '0;
                        word_offset[tgt[0]] = word_offset[tgt[0]] + 8'(len);
                        if (len == 0) push_reply(ST_OK, 1'b0, 8'h00, 1'b1);
                        else data_reads++;
                    end
                end
            end
            OP_LOAD: begin
                if (int'(c.load_index) >= MEM_BYTES) begin
                    push_reply(ST_BAD_ADDR, 1'b0, 8'h00, 1'b1);
                end else begin
                    base = int'(c.bank) * MEM_BYTES + int'(c.load_index);
                    store_shadow[base] = c.write_byte;
                    store_written[base] = 1'b1;
                    push_reply(ST_OK, 1'b0, 8'h00, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_gaps_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Holds one command word until accepted, then idles for a random gap.
    task automatic drive_command(input t_command c);
        int gap;
        i_opcode <= c.opcode;
        i_dev_address <= c.dev_address;
        i_write_count <= c.write_count;
        i_write_byte <= c.write_byte;
        i_bank <= c.bank;
        i_load_index <= c.load_index;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_edid_reply(c);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A read may only touch store entries that were loaded, so missing ones
    // are loaded first.
    task automatic issue_command(input t_command c);
        logic [1:0] tgt;
        int pos;
        int len;
        int entry;
        int i;
        bit beyond;
        tgt = decode_target(c.dev_address);
        if (c.opcode == OP_READ && (tgt == TGT_PRIMARY || tgt == TGT_SECONDARY)) begin
            read_window(tgt, pos, len, beyond);
            for (i = 0; i < len; i++) begin
                entry = int'(tgt[0]) * MEM_BYTES + pos + i;
                if (!store_written[entry])
                    drive_command(make_cmd(OP_LOAD, 7'($urandom), 6'($urandom),
                                           8'($urandom), tgt[0], 10'(pos + i)));
            end
        end
        drive_command(c);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        // Room for an ignored command that has no reply to finish.
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [9:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_PRIMARY_ADDR:   cfg_shadow.primary_address = value[6:0];
            REG_SECONDARY_ADDR: cfg_shadow.secondary_address = value[6:0];
            REG_SEGMENT_ADDR:   cfg_shadow.segment_address = value[6:0];
            REG_PRIMARY_USED:   cfg_shadow.primary_used = value;
            REG_SECONDARY_USED: cfg_shadow.secondary_used = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input t_cfg c);
        write_register(REG_PRIMARY_ADDR, 10'(c.primary_address));
        write_register(REG_SECONDARY_ADDR, 10'(c.secondary_address));
        write_register(REG_SEGMENT_ADDR, 10'(c.segment_address));
        write_register(REG_PRIMARY_USED, c.primary_used);
        write_register(REG_SECONDARY_USED, c.secondary_used);
        settings_applied++;
    endtask

    function automatic t_command random_command();
        t_command c;
        int r;
        c = make_cmd(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                     6'($urandom_range(0, 63)), 8'($urandom), 1'($urandom),
                     10'($urandom_range(0, 1023)));
        r = $urandom_range(0, 99);
        if (r < 40) begin
            c.opcode = OP_READ;
            c.dev_address = $urandom_range(0, 1) ? cfg_shadow.secondary_address
                                                 : cfg_shadow.primary_address;
        end else if (r < 60) begin
            c.opcode = OP_WRITE;
            c.write_count = 6'd1;
            r = $urandom_range(0, 9);
            if (r < 8) begin
                c.dev_address = (r < 4) ? cfg_shadow.primary_address
                                        : cfg_shadow.secondary_address;
                c.write_byte = $urandom_range(0, 1) ? OFFSET_HIGH : OFFSET_LOW;
            end else begin
                c.dev_address = cfg_shadow.segment_address;
                c.write_byte = (r == 8) ? 8'($urandom_range(0, 3))
                                        : 8'($urandom_range(0, 127));
            end
        end else if (r < 75) begin
            c.opcode = OP_LOAD;
        end else if (r < 85) begin
            c.opcode = OP_WRITE;
            case ($urandom_range(0, 2))
                0: c.dev_address = cfg_shadow.primary_address;
                1: c.dev_address = cfg_shadow.secondary_address;
                default: c.dev_address = cfg_shadow.segment_address;
            endcase
        end
        return c;
    endfunction

    // Every result word is checked against the oldest reply still due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (replies_due.size() == 0) begin
                bad_replies++;
                if (bad_replies <= REPORT_CAP)
                    $display("%0t: unexpected result word: expected none, got status %0h",
                             $time, o_status);
            end else begin
                reply_head = replies_due.pop_front();
                replies_checked++;
                compare_field("status", 8'(reply_head.status), 8'(o_status));
                compare_field("data_valid", 8'(reply_head.data_valid), 8'(o_data_valid));
                compare_field("data_byte", reply_head.data_byte, o_data_byte);
                compare_field("last", 8'(reply_head.final_flag), 8'(o_last));
            end
        end
    end

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            bad_replies++;
            if (bad_replies <= REPORT_CAP)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    task automatic test_reset_behavior();
        issue_command(make_cmd(OP_WRITE, 7'd5, 6'd1, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_PRIMARY_ADDR, 6'd0, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_PRIMARY_ADDR, 6'd63, OFFSET_HIGH, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_PRIMARY_ADDR, 6'd1, 8'h81, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_PRIMARY_ADDR, 6'd1, OFFSET_HIGH, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_SECONDARY_ADDR, 6'd1, OFFSET_LOW, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_SEGMENT_ADDR, 6'd1, 8'hFF, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_SEGMENT_ADDR, 6'd1, SEGMENT_MAX, 1'b0, 10'd0));
        issue_command(make_cmd(OP_NONE, 7'd127, 6'd63, 8'hFF, 1'b1, 10'd1023));
        issue_command(make_cmd(OP_READ, RESET_SEGMENT_ADDR, 6'd0, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_READ, 7'd127, 6'd0, 8'h00, 1'b0, 10'd0));
        // The segment pointer puts this far past the used length.
        issue_command(make_cmd(OP_READ, RESET_PRIMARY_ADDR, 6'd0, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, RESET_SEGMENT_ADDR, 6'd1, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_READ, RESET_SECONDARY_ADDR, 6'd0, 8'h00, 1'b0, 10'd0));
    endtask

    task automatic test_bank_reads();
        wait_drained();
        set_config(make_config(7'd0, 7'd127, 7'd1, 10'd4, 10'd258));
        issue_command(make_cmd(OP_WRITE, 7'd0, 6'd1, OFFSET_LOW, 1'b0, 10'd0));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'hFF, 1'b0, 10'd1));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'h5A, 1'b0, 10'd2));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'hA5, 1'b0, 10'd3));
        issue_command(make_cmd(OP_READ, 7'd0, 6'd0, 8'h00, 1'b0, 10'd0));
        // Position now equals the used length: nothing is left to send.
        issue_command(make_cmd(OP_READ, 7'd0, 6'd0, 8'h00, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, 7'd1, 6'd1, 8'h01, 1'b0, 10'd0));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'hC3, 1'b1, 10'd256));
        issue_command(make_cmd(OP_LOAD, 7'd0, 6'd0, 8'h3C, 1'b1, 10'd257));
        issue_command(make_cmd(OP_READ, 7'd127, 6'd0, 8'h00, 1'b0, 10'd0));
    endtask

    task automatic test_address_priority();
        wait_drained();
        set_config(make_config(7'd9, 7'd9, 7'd9, 10'd4, 10'd258));
        // A segment value that a bank rejects shows which target decoded.
        issue_command(make_cmd(OP_WRITE, 7'd9, 6'd1, 8'h05, 1'b0, 10'd0));
        issue_command(make_cmd(OP_READ, 7'd9, 6'd0, 8'h00, 1'b0, 10'd0));
        wait_drained();
        write_register(REG_PRIMARY_ADDR, 10'd10);
        issue_command(make_cmd(OP_WRITE, 7'd9, 6'd1, 8'h05, 1'b0, 10'd0));
        issue_command(make_cmd(OP_WRITE, 7'd9, 6'd1, OFFSET_HIGH, 1'b0, 10'd0));
    endtask

    task automatic test_random_traffic();
        t_cfg plan [RANDOM_PHASES];
        int p;
        int n;
        int phase_end;
        plan[0] = make_config(7'd0, 7'd127, 7'd1, 10'd1023, 10'd1023);
        plan[1] = make_config(7'd127, 7'd0, 7'd127, 10'd0, 10'd300);
        plan[2] = random_config();
        plan[3] = random_config();
        plan[3].secondary_address = plan[3].primary_address;
        plan[4] = random_config();
        plan[5] = make_config(RESET_PRIMARY_ADDR, RESET_SECONDARY_ADDR, RESET_SEGMENT_ADDR,
                              10'd1022, 10'd640);
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            set_config(plan[p]);
            // One phase runs back to back, with no random idle gaps between command words.
            idle_gaps_on = (p != 2);
            // Loads that fill the store ahead of a read count toward the phase.
            phase_end = words_sent + WORDS_PER_PHASE;
            n = 0;
            while (words_sent < phase_end) begin
                if (n == WORDS_PER_PHASE / 8 || $urandom_range(0, 39) == 0) wait_drained();
                issue_command(random_command());
                n++;
            end
        end
        idle_gaps_on = 1'b1;
    endtask

    initial begin
        cfg_shadow = make_config(RESET_PRIMARY_ADDR, RESET_SECONDARY_ADDR,
                                 RESET_SEGMENT_ADDR, 10'd0, 10'd0);
        word_offset[0] = 8'h00;
        word_offset[1] = 8'h00;
        segment_ptr = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_behavior();
        test_bank_reads();
        test_address_priority();
        test_random_traffic();
        wait_drained();

        $display("Sent %0d command words under %0d register settings; %0d results checked.",
                 words_sent, settings_applied + 1, replies_checked);
        $display("Reads that returned data: %0d; failures: %0d.", data_reads, bad_replies);
        if (bad_replies == 0 && replies_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
